>>> rtl/graph_bfs_dfs_traversal_unit_assert.svh
// Assertion macros used by the checker file
`ifndef GRAPH_BFS_DFS_TRAVERSAL_UNIT_ASSERT_SVH
`define GRAPH_BFS_DFS_TRAVERSAL_UNIT_ASSERT_SVH

// Check an implication on every clock edge outside reset
`define GBT_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Check an implication in the cycle after the antecedent
`define GBT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/gbt_pkg.sv
package gbt_pkg;

  typedef enum logic [1:0] {
    MODE_EDGE = 2'd0,
    MODE_BFS  = 2'd1,
    MODE_DFS  = 2'd2,
    MODE_NONE = 2'd3
  } mode_e;

  typedef struct packed {
    logic [1:0] mode;
    logic [5:0] vertex_a;
    logic [5:0] vertex_b;
  } in_word_t;

  typedef struct packed {
    logic [5:0] vertex;
    logic [5:0] parent;
    logic [5:0] depth;
    logic       last;
  } out_word_t;

  // classified command handed from front to back
  typedef struct packed {
    logic       is_edge;
    logic       is_dfs;
    logic [5:0] vertex_a;
    logic [5:0] vertex_b;
  } cmd_t;

  localparam int unsigned CmdDepth = 2;

endpackage

>>> rtl/gbt_front.sv
module gbt_front #(
  parameter int unsigned VERTICES = 64
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  gbt_pkg::in_word_t in_data_i,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  output gbt_pkg::cmd_t    cmd_o,
  output logic             cmd_valid_o,
  input  logic             cmd_take_i
);

  gbt_pkg::cmd_t           fifo_q [gbt_pkg::CmdDepth];
  logic                    wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [1:0]              count_q, count_d;
  logic                    keep, push, pop;
  gbt_pkg::cmd_t           cmd;

  // classify: drop unused mode and out-of-range vertices
  always_comb begin
    cmd.is_edge  = (in_data_i.mode == gbt_pkg::MODE_EDGE);
    cmd.is_dfs   = (in_data_i.mode == gbt_pkg::MODE_DFS);
    cmd.vertex_a = in_data_i.vertex_a;
    cmd.vertex_b = in_data_i.vertex_b;
    keep = (in_data_i.mode != gbt_pkg::MODE_NONE) &&
           (32'(in_data_i.vertex_a) < VERTICES) &&
           (!cmd.is_edge || (32'(in_data_i.vertex_b) < VERTICES));
  end

  assign in_stall_o  = (count_q == 2'(gbt_pkg::CmdDepth));
  assign push        = in_valid_i && !in_stall_o && keep;
  assign cmd_valid_o = (count_q != 2'd0);
  assign pop         = cmd_valid_o && cmd_take_i;
  assign cmd_o       = fifo_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? !wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? !rd_ptr_q : rd_ptr_q;
    count_d  = count_q + 2'(push) - 2'(pop);
  end

  // advance queue pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // hold queue payload
  always_ff @(posedge clk_i) begin
    if (push) fifo_q[wr_ptr_q] <= cmd;
  end

endmodule

>>> rtl/gbt_back.sv
module gbt_back #(
  parameter int unsigned VERTICES = 64
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  gbt_pkg::cmd_t     cmd_i,
  input  logic              cmd_valid_i,
  output logic              cmd_take_o,
  output gbt_pkg::out_word_t out_data_o,
  output logic              out_valid_o,
  input  logic              out_stall_i
);

  localparam int unsigned VW = (VERTICES > 1) ? $clog2(VERTICES) : 1;

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_POP, ST_READ, ST_EMIT, ST_SCAN
  } state_e;

  state_e               state_q;
  logic [VERTICES-1:0]  adj_q [VERTICES];
  logic [VERTICES-1:0]  visited_q, fresh_q;
  logic [5:0]           pend_q [VERTICES];
  logic [5:0]           par_q [VERTICES];
  logic [5:0]           dep_q [VERTICES];
  logic [VW:0]          head_q, tail_q;
  logic                 dfs_q;
  logic [VW-1:0]        cur_q;
  logic [VW-1:0]        clr_q;
  logic [5:0]           cur_dep_q;
  gbt_pkg::out_word_t   out_q;
  logic                 out_valid_q;
  logic [VW-1:0]        pick;
  logic                 any_fresh;
  logic                 emit;
  logic [VW-1:0]        va, vb;

  assign va = cmd_i.vertex_a[VW-1:0];
  assign vb = cmd_i.vertex_b[VW-1:0];

  // pick lowest pending neighbor
  always_comb begin
    pick = '0;
    any_fresh = |fresh_q;
    for (int i = VERTICES - 1; i >= 0; i--) begin
      if (fresh_q[i]) pick = VW'(i);
    end
  end

  assign cmd_take_o  = (state_q == ST_IDLE) && cmd_valid_i;
  assign emit        = (state_q == ST_EMIT) && (!out_valid_q || !out_stall_i);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // adjacency rows: zero one row per cycle after reset, set symmetric bits on edge words
  always_ff @(posedge clk_i) begin
    if (state_q == ST_CLEAR) begin
      adj_q[clr_q] <= '0;
    end else if (cmd_take_o && cmd_i.is_edge) begin
      adj_q[va][vb] <= 1'b1;
      if (va != vb) adj_q[vb][va] <= 1'b1;
    end
  end

  // traversal sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      out_valid_q <= 1'b0;
      head_q      <= '0;
      tail_q      <= '0;
      visited_q   <= '0;
      fresh_q     <= '0;
      dfs_q       <= 1'b0;
      cur_q       <= '0;
      cur_dep_q   <= '0;
      out_q       <= '0;
    end else begin
      if (emit) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
      unique case (state_q)
        ST_CLEAR: begin
          clr_q <= clr_q + VW'(1);
          if (clr_q == VW'(VERTICES - 1)) state_q <= ST_IDLE;
        end
        ST_IDLE: begin
          if (cmd_take_o && !cmd_i.is_edge) begin
            dfs_q     <= cmd_i.is_dfs;
            visited_q <= VERTICES'(1) << va;
            pend_q[0] <= cmd_i.vertex_a;
            par_q[va] <= cmd_i.vertex_a;
            dep_q[va] <= '0;
            head_q    <= '0;
            tail_q    <= (VW+1)'(1);
            state_q   <= ST_POP;
          end
        end
        ST_POP: begin
          if (dfs_q) begin
            cur_q  <= pend_q[tail_q[VW-1:0] - VW'(1)][VW-1:0];
            tail_q <= tail_q - (VW+1)'(1);
          end else begin
            cur_q  <= pend_q[head_q[VW-1:0]][VW-1:0];
            head_q <= head_q + (VW+1)'(1);
          end
          state_q <= ST_READ;
        end
        ST_READ: begin
          fresh_q   <= adj_q[cur_q] & ~visited_q;
          cur_dep_q <= dep_q[cur_q];
          state_q   <= ST_EMIT;
        end
        ST_EMIT: begin
          if (emit) begin
            out_q.vertex <= 6'(cur_q);
            out_q.parent <= par_q[cur_q];
            out_q.depth  <= cur_dep_q;
            out_q.last   <= !any_fresh && (head_q == tail_q);
            state_q      <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (any_fresh) begin
            visited_q[pick]         <= 1'b1;
            fresh_q[pick]           <= 1'b0;
            par_q[pick]             <= 6'(cur_q);
            dep_q[pick]             <= cur_dep_q + 6'd1;
            pend_q[tail_q[VW-1:0]]  <= 6'(pick);
            tail_q                  <= tail_q + (VW+1)'(1);
          end else begin
            state_q <= (head_q == tail_q) ? ST_IDLE : ST_POP;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

>>> rtl/graph_bfs_dfs_traversal_unit.sv
// Edge word: waits in the front queue, taken when the back is idle; no result.
// Traversal: each reached vertex passes through pop, row read, emit and a priority
// scan over its new neighbors; emit holds while results stall; one traversal at a time.
// First result: the back takes the word, then steps through pop, row read and emit.
// Reset (async, active low) clears queue and control; a clear pass then zeroes
// the adjacency rows one at a time while input words wait in the front queue.
module graph_bfs_dfs_traversal_unit #(
  parameter int unsigned VERTICES = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  gbt_pkg::in_word_t  in_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  output gbt_pkg::out_word_t out_data_o,
  output logic               out_valid_o,
  input  logic               out_stall_i
);

  gbt_pkg::cmd_t cmd;
  logic          cmd_valid, cmd_take;

  gbt_front #(.VERTICES(VERTICES)) u_front (
    .clk_i, .rst_ni, .in_data_i, .in_valid_i, .in_stall_o,
    .cmd_o(cmd), .cmd_valid_o(cmd_valid), .cmd_take_i(cmd_take)
  );

  gbt_back #(.VERTICES(VERTICES)) u_back (
    .clk_i, .rst_ni, .cmd_i(cmd), .cmd_valid_i(cmd_valid), .cmd_take_o(cmd_take),
    .out_data_o, .out_valid_o, .out_stall_i
  );

endmodule

>>> rtl/gbt_checker.sv
`include "graph_bfs_dfs_traversal_unit_assert.svh"
module gbt_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input gbt_pkg::in_word_t  in_data_i,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input gbt_pkg::out_word_t out_data_o,
  input logic               out_valid_o,
  input logic               out_stall_i
);

  logic out_wait, in_wait, root_word, child_word;

  assign out_wait   = out_valid_o && out_stall_i;
  assign in_wait    = in_valid_i && in_stall_o;
  assign root_word  = out_valid_o && (out_data_o.depth == 6'd0);
  assign child_word = out_valid_o && (out_data_o.depth != 6'd0);

  // a stalled result word holds
  `GBT_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_wait, out_valid_o && $stable(out_data_o), "held")
  // a stalled input word holds
  `GBT_ASSERT_NEXT(a_in_hold, clk_i, rst_ni, in_wait, in_valid_i && $stable(in_data_i), "held")
  // the start vertex of a walk is its own parent at depth zero
  `GBT_ASSERT_IMP(a_root, clk_i, rst_ni, root_word, out_data_o.parent == out_data_o.vertex, "root")
  // a nonroot vertex is never its own parent
  `GBT_ASSERT_IMP(a_nonroot, clk_i, rst_ni, child_word, out_data_o.parent != out_data_o.vertex, "child")

endmodule

bind graph_bfs_dfs_traversal_unit gbt_checker u_gbt_checker (
  .clk_i, .rst_ni, .in_data_i, .in_valid_i, .in_stall_o, .out_data_o, .out_valid_o, .out_stall_i
);
